/* src/qubo_pkg.sv */
// Package for the QUBO one/two-flip local search block.
// Holds default sizes, fixed field widths, the run limit and the opcode type.
// No dependencies.
package qubo_pkg;

  localparam int MAX_VARS_DEF  = 64;
  localparam int COEF_BITS_DEF = 16;
  localparam int MOVE_LIMIT    = 4096;
  localparam int GAIN_BITS     = 24;
  localparam int OBJ_BITS      = 28;
  localparam int IN_IDX_BITS   = 6;
  localparam int IN_COEF_BITS  = 16;
  localparam int CNT_REG_BITS  = 7;

  typedef enum logic [1:0] {
    OP_COEF  = 2'd0,
    OP_START = 2'd1,
    OP_RUN   = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

endpackage

/* src/qubo_one_two_flip_local_search.sv */
// QUBO one/two-flip greedy local search, top level.
// Depends on qubo_pkg.
//
// Items are matrix writes, start-bit writes and run commands, one at a time.
// A run repeats moves: a gain pass over n*n coefficients, a pair pass over n*n
// coefficients, a single pass over n gains and a decide step. The run ends when
// no move lowers x'Qx or after 4096 moves, then makes one objective pass over
// n*n coefficients and emits n result items, one per bit.
module qubo_one_two_flip_local_search
  import qubo_pkg::*;
#(
  parameter int MAX_VARS  = MAX_VARS_DEF,
  parameter int COEF_BITS = COEF_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // row_index, col_index, coef_value, start_bit
  input  logic [1:0]  in_tuser,   // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // var_index, var_bit, objective
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int IDX_W  = (MAX_VARS > 2) ? $clog2(MAX_VARS) : 1;
  localparam int CNT_W  = $clog2(MAX_VARS + 1);
  localparam int ADDR_W = 2 * IDX_W;
  localparam int ACC_W  = COEF_BITS + IDX_W + 2;
  localparam int PAIR_W = ((COEF_BITS + 2 > GAIN_BITS + 2) ? COEF_BITS + 2 : GAIN_BITS + 2) + 1;
  localparam int OBJ_W  = COEF_BITS + ADDR_W + 1;
  localparam int GS_W   = (ACC_W + 1 > GAIN_BITS) ? ACC_W + 1 : GAIN_BITS;
  localparam int OS_W   = (OBJ_W > OBJ_BITS) ? OBJ_W : OBJ_BITS;
  localparam int MOVE_W = $clog2(MOVE_LIMIT + 1);
  localparam logic signed [GS_W-1:0] G_HI = GS_W'((longint'(1) <<< (GAIN_BITS - 1)) - 1);
  localparam logic signed [GS_W-1:0] G_LO = -G_HI - 1;
  localparam logic signed [OS_W-1:0] O_HI = OS_W'((longint'(1) <<< (OBJ_BITS - 1)) - 1);
  localparam logic signed [OS_W-1:0] O_LO = -O_HI - 1;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_GAIN   = 7'b0000010,
    S_PAIR   = 7'b0000100,
    S_SINGLE = 7'b0001000,
    S_DECIDE = 7'b0010000,
    S_OBJ    = 7'b0100000,
    S_EMIT   = 7'b1000000
  } state_t;

  state_t                         state_r;
  logic [CNT_REG_BITS-1:0]        var_count_r;
  logic [MAX_VARS-1:0]            x_r;
  logic [CNT_W-1:0]               n_r;
  logic [IDX_W-1:0]               ci_r, cj_r, p_i_r, p_j_r, pa_r, pb_r, sg_r, oidx_r;
  logic                           iss_r, p_vld_r, have_single_r, out_vld_r;
  logic [MOVE_W-1:0]              moves_r;
  logic signed [ACC_W-1:0]        acc_r;
  logic signed [OBJ_W-1:0]        obj_sum_r;
  logic signed [PAIR_W-1:0]       best_r;
  logic signed [OBJ_BITS-1:0]     obj_r;
  logic signed [COEF_BITS-1:0]    coef_mem [2**ADDR_W];
  logic signed [GAIN_BITS-1:0]    gain_mem [MAX_VARS];
  logic signed [COEF_BITS-1:0]    coef_q_r;
  logic signed [GAIN_BITS-1:0]    gi_q_r, gj_q_r;

  logic [IDX_W-1:0]               n_last, in_row, in_col;
  logic                           in_acc, row_ok, col_ok, last_j, last_i, drained;
  opcode_t                        op;
  logic signed [ACC_W-1:0]        acc_sum;
  logic signed [GS_W-1:0]         gain_x;
  logic signed [GAIN_BITS-1:0]    gain_sat;
  logic signed [PAIR_W-1:0]       q2, pair_g, gj_ext;
  logic signed [OS_W-1:0]         obj_x;
  logic signed [OBJ_BITS-1:0]     obj_sat;
  logic [CNT_W-1:0]               n_nxt;

  assign op      = opcode_t'(in_tuser);
  assign in_acc  = in_tvalid && in_tready;
  assign in_row  = IDX_W'(in_tdata[5:0]);
  assign in_col  = IDX_W'(in_tdata[11:6]);
  assign row_ok  = 32'(in_tdata[5:0]) < 32'(MAX_VARS);
  assign col_ok  = 32'(in_tdata[11:6]) < 32'(MAX_VARS);
  assign n_last  = IDX_W'(n_r - CNT_W'(1));
  assign last_j  = cj_r == n_last;
  assign last_i  = ci_r == n_last;
  assign drained = !iss_r && !p_vld_r;

  always_comb begin
    if (var_count_r == '0) begin
      n_nxt = CNT_W'(1);
    end else if (32'(var_count_r) > 32'(MAX_VARS)) begin
      n_nxt = CNT_W'(MAX_VARS);
    end else begin
      n_nxt = CNT_W'(var_count_r);
    end
  end

  always_comb begin
    if (p_j_r == p_i_r) begin
      acc_sum = acc_r + ACC_W'(coef_q_r);
    end else if (x_r[p_j_r]) begin
      acc_sum = acc_r + (ACC_W'(coef_q_r) <<< 1);
    end else begin
      acc_sum = acc_r;
    end
    gain_x = x_r[p_i_r] ? -GS_W'(acc_sum) : GS_W'(acc_sum);
    if (gain_x > G_HI) begin
      gain_sat = GAIN_BITS'(G_HI);
    end else if (gain_x < G_LO) begin
      gain_sat = GAIN_BITS'(G_LO);
    end else begin
      gain_sat = GAIN_BITS'(gain_x);
    end
    q2     = PAIR_W'(coef_q_r) <<< 1;
    gj_ext = PAIR_W'(gj_q_r);
    pair_g = ((x_r[p_i_r] != x_r[p_j_r]) ? -q2 : q2) + PAIR_W'(gi_q_r) + gj_ext;
    obj_x  = OS_W'(obj_sum_r);
    if (obj_x > O_HI) begin
      obj_sat = OBJ_BITS'(O_HI);
    end else if (obj_x < O_LO) begin
      obj_sat = OBJ_BITS'(O_LO);
    end else begin
      obj_sat = OBJ_BITS'(obj_x);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && op == OP_COEF && row_ok && col_ok) begin
      coef_mem[{in_row, in_col}] <= COEF_BITS'($signed(in_tdata[27:12]));
    end
    coef_q_r <= coef_mem[{ci_r, cj_r}];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_GAIN && p_vld_r && p_j_r == n_last) begin
      gain_mem[p_i_r] <= gain_sat;
    end
    gi_q_r <= gain_mem[ci_r];
    gj_q_r <= gain_mem[cj_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      var_count_r <= CNT_REG_BITS'(64);
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      var_count_r <= cfg_pwdata[CNT_REG_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      x_r           <= '0;
      n_r           <= CNT_W'(1);
      ci_r          <= '0;
      cj_r          <= '0;
      iss_r         <= 1'b0;
      p_vld_r       <= 1'b0;
      have_single_r <= 1'b0;
      out_vld_r     <= 1'b0;
      moves_r       <= '0;
      oidx_r        <= '0;
    end else begin
      p_vld_r <= iss_r;
      if (iss_r) begin
        p_i_r   <= ci_r;
        p_j_r   <= cj_r;
        if (last_j) begin
          cj_r <= '0;
          if (last_i || state_r == S_SINGLE) begin
            iss_r <= 1'b0;
          end else begin
            ci_r <= ci_r + 1'b1;
          end
        end else begin
          cj_r <= cj_r + 1'b1;
        end
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (op == OP_START && row_ok) begin
              x_r[in_row] <= in_tdata[28];
            end
            if (op == OP_RUN) begin
              n_r     <= n_nxt;
              moves_r <= '0;
              ci_r    <= '0;
              cj_r    <= '0;
              iss_r   <= 1'b1;
              acc_r   <= '0;
              state_r <= S_GAIN;
            end
          end
        end
        S_GAIN: begin
          if (p_vld_r) begin
            acc_r <= (p_j_r == n_last) ? '0 : acc_sum;
          end
          if (drained) begin
            ci_r          <= '0;
            cj_r          <= '0;
            iss_r         <= 1'b1;
            best_r        <= '0;
            have_single_r <= 1'b0;
            state_r       <= S_PAIR;
          end
        end
        S_PAIR: begin
          if (p_vld_r && p_i_r != p_j_r && pair_g < best_r) begin
            best_r <= pair_g;
            pa_r   <= p_i_r;
            pb_r   <= p_j_r;
          end
          if (drained) begin
            ci_r    <= '0;
            cj_r    <= '0;
            iss_r   <= 1'b1;
            state_r <= S_SINGLE;
          end
        end
        S_SINGLE: begin
          if (p_vld_r && gj_ext < best_r) begin
            best_r        <= gj_ext;
            sg_r          <= p_j_r;
            have_single_r <= 1'b1;
          end
          if (drained) begin
            state_r <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          ci_r      <= '0;
          cj_r      <= '0;
          iss_r     <= 1'b1;
          acc_r     <= '0;
          obj_sum_r <= '0;
          if (!best_r[PAIR_W-1]) begin
            state_r <= S_OBJ;
          end else begin
            if (have_single_r) begin
              x_r[sg_r] <= !x_r[sg_r];
            end else begin
              x_r <= x_r ^ (MAX_VARS'(1) << pa_r) ^ (MAX_VARS'(1) << pb_r);
            end
            moves_r <= moves_r + 1'b1;
            state_r <= (moves_r == MOVE_W'(MOVE_LIMIT - 1)) ? S_OBJ : S_GAIN;
          end
        end
        S_OBJ: begin
          if (p_vld_r && x_r[p_i_r] && x_r[p_j_r]) begin
            obj_sum_r <= obj_sum_r + OBJ_W'(coef_q_r);
          end
          if (drained) begin
            obj_r     <= obj_sat;
            oidx_r    <= '0;
            out_vld_r <= 1'b1;
            state_r   <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_vld_r && out_tready) begin
            if (oidx_r == n_last) begin
              out_vld_r <= 1'b0;
              state_r   <= S_IDLE;
            end else begin
              oidx_r <= oidx_r + 1'b1;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_tready  = state_r == S_IDLE;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {5'd0, obj_r, x_r[oidx_r], IN_IDX_BITS'(oidx_r)};
  assign out_tlast  = oidx_r == n_last;
  assign cfg_prdata = {{(32 - CNT_REG_BITS){1'b0}}, var_count_r};
  assign cfg_pready = 1'b1;

  logic unused_addr;
  assign unused_addr = ^cfg_paddr ^ ^in_tdata[31:29];

endmodule
